FILE: design/gfcd_pkg.sv
package gfcd_pkg;

  localparam int DIGIT_COUNT_DEF = 5;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int GATE_W    = 16;
  localparam int SCAN_W    = 8;
  localparam int SELECT_W  = 5;
  localparam int PATTERN_W = 8;
  localparam int FREQ_W    = 16;
  localparam int DIGIT_W   = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [GATE_W-1:0] GATE_TICKS_RST = 16'd5000;
  localparam logic [SCAN_W-1:0] SCAN_TICKS_RST = 8'd2;
  localparam logic              INVERT_RST     = 1'b1;

  localparam logic [PATTERN_W-1:0] BLANK_PATTERN = 8'h00;
  localparam logic [PATTERN_W-1:0] PATTERN_RST   =
    INVERT_RST ? ~BLANK_PATTERN : BLANK_PATTERN;
  localparam logic [SELECT_W-1:0]  SELECT_FIRST  = 5'h10;

  typedef enum logic [1:0] {
    REG_GATE_TICKS,
    REG_SCAN_TICKS,
    REG_INVERT_SEGMENTS
  } cfg_reg_t;

  typedef struct packed {
    logic              scan_fire;
    logic              invert;
    logic              seen;
    logic              fresh;
    logic [FREQ_W-1:0] freq;
  } ctrl_t;

  function automatic logic [PATTERN_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    logic [PATTERN_W-1:0] p;
    case (d)
      4'd0: p = 8'h3F;
      4'd1: p = 8'h06;
      4'd2: p = 8'h5B;
      4'd3: p = 8'h4F;
      4'd4: p = 8'h66;
      4'd5: p = 8'h6D;
      4'd6: p = 8'h7D;
      4'd7: p = 8'h07;
      4'd8: p = 8'h7F;
      4'd9: p = 8'h6F;
      default: p = BLANK_PATTERN;
    endcase
    return p;
  endfunction

endpackage

FILE: design/gfcd_count.sv
module gfcd_count #(
  parameter int DIGIT_COUNT = gfcd_pkg::DIGIT_COUNT_DEF,
  parameter int COUNT_BITS  = gfcd_pkg::COUNT_BITS_DEF,
  parameter int POS_W       = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic                          pulse_edge,
  input  logic                          base_tick,
  input  logic [gfcd_pkg::GATE_W-1:0]   gate_ticks,
  input  logic [gfcd_pkg::SCAN_W-1:0]   scan_ticks,
  input  logic                          invert_segments,
  input  logic                          a_ready,
  output logic                          a_valid,
  output gfcd_pkg::ctrl_t               a_ctrl,
  output logic [COUNT_BITS-1:0]         a_value,
  output logic [POS_W-1:0]              a_pos
);
  import gfcd_pkg::*;

  logic [COUNT_BITS-1:0] pulse_r, pulse_nxt, pulse_inc;
  logic [GATE_W-1:0]     gate_r, gate_nxt, gate_inc;
  logic [SCAN_W-1:0]     scan_r, scan_nxt, scan_inc;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  seen_r, seen_nxt;
  logic [COUNT_BITS-1:0] latched_r, latched_nxt;
  logic                  latch, fire, advance, xfer;

  logic                  a_valid_r;
  ctrl_t                 a_ctrl_r;
  logic [COUNT_BITS-1:0] a_value_r;
  logic [POS_W-1:0]      a_pos_r;

  assign advance   = !a_valid_r || a_ready;
  assign in_tready = advance;
  assign xfer      = in_tvalid && advance;

  always_comb begin
    pulse_inc   = pulse_r + COUNT_BITS'(pulse_edge);
    gate_inc    = gate_r + GATE_W'(1);
    scan_inc    = scan_r + SCAN_W'(1);
    latch       = base_tick && (gate_inc >= gate_ticks);
    fire        = base_tick && (scan_inc >= scan_ticks);
    pulse_nxt   = pulse_inc;
    gate_nxt    = gate_r;
    scan_nxt    = scan_r;
    pos_nxt     = pos_r;
    seen_nxt    = seen_r;
    latched_nxt = latched_r;
    if (base_tick) begin
      gate_nxt = latch ? '0 : gate_inc;
      scan_nxt = fire ? '0 : scan_inc;
    end
    if (latch) begin
      latched_nxt = pulse_inc;
      pulse_nxt   = '0;
      seen_nxt    = 1'b1;
    end
    if (fire) begin
      pos_nxt = (pos_r == POS_W'(DIGIT_COUNT - 1)) ? '0 : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r   <= '0;
      gate_r    <= '0;
      scan_r    <= '0;
      pos_r     <= '0;
      seen_r    <= 1'b0;
      latched_r <= '0;
      a_valid_r <= 1'b0;
    end else begin
      if (xfer) begin
        pulse_r   <= pulse_nxt;
        gate_r    <= gate_nxt;
        scan_r    <= scan_nxt;
        pos_r     <= pos_nxt;
        seen_r    <= seen_nxt;
        latched_r <= latched_nxt;
      end
      if (advance) begin
        a_valid_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      a_ctrl_r.scan_fire <= fire;
      a_ctrl_r.invert    <= invert_segments;
      a_ctrl_r.seen      <= seen_nxt;
      a_ctrl_r.fresh     <= latch;
      a_ctrl_r.freq      <= FREQ_W'(latched_nxt);
      a_value_r          <= latched_nxt;
      a_pos_r            <= pos_r;
    end
  end

  assign a_valid = a_valid_r;
  assign a_ctrl  = a_ctrl_r;
  assign a_value = a_value_r;
  assign a_pos   = a_pos_r;

  a_fresh_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_ctrl_r.fresh) |-> a_ctrl_r.seen)
    else $error("reading flagged before any latch");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) < DIGIT_COUNT)
    else $error("scan position out of range");

endmodule

FILE: design/gfcd_digit.sv
module gfcd_digit #(
  parameter int DIGIT_COUNT = gfcd_pkg::DIGIT_COUNT_DEF,
  parameter int COUNT_BITS  = gfcd_pkg::COUNT_BITS_DEF,
  parameter int POS_W       = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             a_valid,
  output logic                             a_ready,
  input  gfcd_pkg::ctrl_t                  a_ctrl,
  input  logic [COUNT_BITS-1:0]            a_value,
  input  logic [POS_W-1:0]                 a_pos,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [gfcd_pkg::SELECT_W-1:0]    out_select,
  output logic [gfcd_pkg::PATTERN_W-1:0]   out_pattern,
  output logic [gfcd_pkg::FREQ_W-1:0]      out_freq,
  output logic                             out_fresh
);
  import gfcd_pkg::*;

  localparam int MW     = COUNT_BITS + 1;
  localparam int PROD_W = COUNT_BITS + MW;
  localparam int SH_W   = $clog2(COUNT_BITS + 25);
  localparam int S10    = COUNT_BITS + 4;
  localparam longint unsigned M10 = ((64'd1 << S10) / 64'd10) + 64'd1;

  logic [MW-1:0]   mul_tab [DIGIT_COUNT];
  logic [SH_W-1:0] sh_tab  [DIGIT_COUNT];

  for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_recip
    localparam longint unsigned DIV_K = 64'(10 ** k);
    localparam int              SH_K  = COUNT_BITS + $clog2(10 ** k);
    localparam longint unsigned M_K   = ((64'd1 << SH_K) / DIV_K) + 64'd1;
    assign mul_tab[k] = MW'(M_K);
    assign sh_tab[k]  = SH_W'(SH_K);
  end

  // decade quotient
  logic                  b_valid_r;
  ctrl_t                 b_ctrl_r;
  logic [POS_W-1:0]      b_pos_r;
  logic [PROD_W-1:0]     b_prod_r;
  // mod-ten product
  logic                  c_valid_r;
  ctrl_t                 c_ctrl_r;
  logic [POS_W-1:0]      c_pos_r;
  logic [COUNT_BITS-1:0] c_q_r;
  logic [PROD_W-1:0]     c_prod_r;
  // drive and output
  logic [SELECT_W-1:0]   select_drive_r, select_nxt;
  logic [PATTERN_W-1:0]  pattern_drive_r, pattern_nxt, pat_raw;
  logic                  out_valid_r;
  logic [SELECT_W-1:0]   out_select_r;
  logic [PATTERN_W-1:0]  out_pattern_r;
  logic [FREQ_W-1:0]     out_freq_r;
  logic                  out_fresh_r;

  logic                  b_adv, c_adv, d_adv;
  logic [COUNT_BITS-1:0] q_b, q10, rem;
  logic [DIGIT_W-1:0]    digit;

  assign d_adv   = !out_valid_r || out_ready;
  assign c_adv   = !c_valid_r || d_adv;
  assign b_adv   = !b_valid_r || c_adv;
  assign a_ready = b_adv;

  always_comb begin
    q_b   = COUNT_BITS'(b_prod_r >> sh_tab[b_pos_r]);
    q10   = COUNT_BITS'(c_prod_r >> S10);
    rem   = c_q_r - COUNT_BITS'(q10 * COUNT_BITS'(10));
    digit = DIGIT_W'(rem);
    pat_raw     = c_ctrl_r.seen ? seg_pattern(digit) : BLANK_PATTERN;
    select_nxt  = select_drive_r;
    pattern_nxt = pattern_drive_r;
    if (c_ctrl_r.scan_fire) begin
      pattern_nxt = c_ctrl_r.invert ? ~pat_raw : pat_raw;
      select_nxt  = (32'(c_pos_r) < SELECT_W) ? SELECT_W'(SELECT_FIRST >> c_pos_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r       <= 1'b0;
      c_valid_r       <= 1'b0;
      out_valid_r     <= 1'b0;
      select_drive_r  <= '0;
      pattern_drive_r <= PATTERN_RST;
    end else begin
      if (b_adv) begin
        b_valid_r <= a_valid;
      end
      if (c_adv) begin
        c_valid_r <= b_valid_r;
      end
      if (d_adv) begin
        out_valid_r <= c_valid_r;
        if (c_valid_r) begin
          select_drive_r  <= select_nxt;
          pattern_drive_r <= pattern_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_valid) begin
      b_ctrl_r <= a_ctrl;
      b_pos_r  <= a_pos;
      b_prod_r <= PROD_W'(a_value * mul_tab[a_pos]);
    end
    if (c_adv && b_valid_r) begin
      c_ctrl_r <= b_ctrl_r;
      c_pos_r  <= b_pos_r;
      c_q_r    <= q_b;
      c_prod_r <= PROD_W'(q_b * MW'(M10));
    end
    if (d_adv && c_valid_r) begin
      out_select_r  <= select_nxt;
      out_pattern_r <= pattern_nxt;
      out_freq_r    <= c_ctrl_r.freq;
      out_fresh_r   <= c_ctrl_r.fresh;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_select  = out_select_r;
  assign out_pattern = out_pattern_r;
  assign out_freq    = out_freq_r;
  assign out_fresh   = out_fresh_r;

  a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(select_drive_r))
    else $error("more than one digit enabled");

  a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && c_ctrl_r.scan_fire && c_ctrl_r.seen) |-> (digit <= DIGIT_W'(9)))
    else $error("digit split gave a non-decimal digit");

  a_blank_before_reading: assert property (@(posedge clk) disable iff (!rst_n)
    (d_adv && c_valid_r && c_ctrl_r.scan_fire && !c_ctrl_r.seen) |=>
    (pattern_drive_r == ($past(c_ctrl_r.invert) ? ~BLANK_PATTERN : BLANK_PATTERN)))
    else $error("digit drawn before first reading");

endmodule

FILE: design/gated_frequency_counter_display_core.sv
// Gated frequency counter with a multiplexed seven-segment display scan. Each input transfer
// is one sampled clock event carrying a pulse edge and/or a base tick; every input transfer
// yields exactly one output transfer holding the current digit select, segment pattern, last
// reading and a new-reading flag. One transfer is taken per clock unless out_tready stalls it;
// a result passes the counter stage register, then the digit path registers (reciprocal
// multiply by the scanned decade, mod-ten multiply, segment lookup and polarity).
// Configuration must be written only while no transfer is in flight; the block does not hold
// off writes by itself.
module gated_frequency_counter_display_core #(
  parameter int DIGIT_COUNT = gfcd_pkg::DIGIT_COUNT_DEF,
  parameter int COUNT_BITS  = gfcd_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,    // pulse_edge, base_tick
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,   // digit_select, segment_drive, frequency
  output logic                              out_tuser,   // new_reading
  input  logic                              cfg_wr_en,
  input  logic [1:0]                        cfg_index,
  input  logic [gfcd_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import gfcd_pkg::*;

  localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [GATE_W-1:0]     gate_ticks_r;
  logic [SCAN_W-1:0]     scan_ticks_r;
  logic                  invert_r;

  logic                  a_valid, a_ready;
  ctrl_t                 a_ctrl;
  logic [COUNT_BITS-1:0] a_value;
  logic [POS_W-1:0]      a_pos;

  logic [SELECT_W-1:0]   out_select;
  logic [PATTERN_W-1:0]  out_pattern;
  logic [FREQ_W-1:0]     out_freq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_ticks_r <= GATE_TICKS_RST;
      scan_ticks_r <= SCAN_TICKS_RST;
      invert_r     <= INVERT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_GATE_TICKS:      gate_ticks_r <= GATE_W'(cfg_wr_data);
        REG_SCAN_TICKS:      scan_ticks_r <= SCAN_W'(cfg_wr_data);
        REG_INVERT_SEGMENTS: invert_r     <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  gfcd_count #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .COUNT_BITS  (COUNT_BITS),
    .POS_W       (POS_W)
  ) u_count (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .pulse_edge      (in_tdata[0]),
    .base_tick       (in_tdata[1]),
    .gate_ticks      (gate_ticks_r),
    .scan_ticks      (scan_ticks_r),
    .invert_segments (invert_r),
    .a_ready         (a_ready),
    .a_valid         (a_valid),
    .a_ctrl          (a_ctrl),
    .a_value         (a_value),
    .a_pos           (a_pos)
  );

  gfcd_digit #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .COUNT_BITS  (COUNT_BITS),
    .POS_W       (POS_W)
  ) u_digit (
    .clk         (clk),
    .rst_n       (rst_n),
    .a_valid     (a_valid),
    .a_ready     (a_ready),
    .a_ctrl      (a_ctrl),
    .a_value     (a_value),
    .a_pos       (a_pos),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_select  (out_select),
    .out_pattern (out_pattern),
    .out_freq    (out_freq),
    .out_fresh   (out_tuser)
  );

  assign out_tdata = {3'b000, out_freq, out_pattern, out_select};

endmodule
